@@ hdl/bam_rs_pkg.sv @@
`timescale 1ns / 1ps
package bam_rs_pkg;

  localparam int DEF_MAX_BLOCK_BYTES = 65536;
  localparam int DEF_MAX_BLOCKS      = 65536;
  localparam logic [15:0] DEF_MIN_BODY_SIZE = 16'd32;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    FAULT_NONE       = 2'd0,
    FAULT_TRUNC_LEN  = 2'd1,
    FAULT_SMALL_LEN  = 2'd2,
    FAULT_TRUNC_BODY = 2'd3
  } fault_t;

  typedef enum logic {
    PHASE_LENGTH = 1'b0,
    PHASE_BODY   = 1'b1
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       has_byte;
    logic       block_end;
    logic       batch_start;
  } in_item_t;

  typedef struct packed {
    logic        record_ready;
    logic [15:0] record_offset;
    logic [16:0] total_size;
    logic [15:0] body_size;
    logic [15:0] block_number;
    logic [1:0]  fault_code;
  } out_item_t;

  // work item handed from the front to the back
  typedef struct packed {
    logic [7:0] byte_value;
    logic       has_byte;
    logic       block_end;
    logic       batch_start;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

@@ hdl/bam_rs_front.sv @@
`timescale 1ns / 1ps
module bam_rs_front
  import bam_rs_pkg::*;
(
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  q_status_t q_status,
  output logic      push,
  output cmd_t      push_data
);

  logic no_op;

  // an item with no byte, no block end and no batch start changes nothing
  assign no_op = !in_data.has_byte && !in_data.block_end && !in_data.batch_start;

  assign in_ready = !q_status.full;
  assign push     = in_valid && !q_status.full && !no_op;

  assign push_data.byte_value  = in_data.byte_value;
  assign push_data.has_byte    = in_data.has_byte;
  assign push_data.block_end   = in_data.block_end;
  assign push_data.batch_start = in_data.batch_start;

endmodule

@@ hdl/bam_rs_queue.sv @@
`timescale 1ns / 1ps
module bam_rs_queue
  import bam_rs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_data,
  input  logic      pop,
  output cmd_t      pop_data,
  output q_status_t q_status
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign q_status.full     = (count == CW'(QUEUE_DEPTH));
  assign q_status.nonempty = (count != '0);
  assign pop_data          = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/bam_rs_back.sv @@
`timescale 1ns / 1ps
module bam_rs_back
  import bam_rs_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
  parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] min_body_size,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int OW  = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int RW  = $clog2(MAX_BLOCK_BYTES);
  localparam int BCW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [OW-1:0] MAX_OFF  = OW'(MAX_BLOCK_BYTES);
  localparam logic [32:0]   MAX_SPAN = 33'(MAX_BLOCK_BYTES);
  localparam logic [BCW-1:0] LAST_BLOCK = BCW'(MAX_BLOCKS - 1);

  // deframer state
  phase_t         phase;
  logic [1:0]     prefix_bytes_seen;
  logic [31:0]    length_shift;
  logic [OW-1:0]  body_left;
  logic [RW-1:0]  record_start;
  logic [OW-1:0]  offset_in_block;
  logic [BCW-1:0] block_counter;
  logic           fault_latched;

  phase_t         phase_next;
  logic [1:0]     prefix_bytes_seen_next;
  logic [31:0]    length_shift_next;
  logic [OW-1:0]  body_left_next;
  logic [RW-1:0]  record_start_next;
  logic [OW-1:0]  offset_in_block_next;
  logic [BCW-1:0] block_counter_next;
  logic           fault_latched_next;

  // view of the state after an optional batch start
  phase_t         e_phase;
  logic [1:0]     e_pbs;
  logic [31:0]    e_ls;
  logic [OW-1:0]  e_bl;
  logic [RW-1:0]  e_rs;
  logic [OW-1:0]  e_off;
  logic [BCW-1:0] e_bc;
  logic           e_fault;

  logic        rec_done;
  logic        fault_hit;
  fault_t      fault_kind;
  logic [RW-1:0] rep_start;
  logic [16:0] rep_enc;
  logic [15:0] rep_body;

  out_item_t   res;
  out_item_t   res_next;
  logic        res_valid;
  logic [RW+15:0]  start_wide;
  logic [BCW+15:0] block_wide;

  assign pop       = cmd_valid && (!res_valid || out_ready);
  assign out_valid = res_valid;
  assign out_data  = res;

  always_comb begin
    if (cmd.batch_start) begin
      e_phase = PHASE_LENGTH;
      e_pbs   = '0;
      e_ls    = '0;
      e_bl    = '0;
      e_rs    = '0;
      e_off   = '0;
      e_bc    = '0;
      e_fault = 1'b0;
    end else begin
      e_phase = phase;
      e_pbs   = prefix_bytes_seen;
      e_ls    = length_shift;
      e_bl    = body_left;
      e_rs    = record_start;
      e_off   = offset_in_block;
      e_bc    = block_counter;
      e_fault = fault_latched;
    end
  end

  // next state
  always_comb begin
    logic [32:0] span;
    phase_next             = e_phase;
    prefix_bytes_seen_next = e_pbs;
    length_shift_next      = e_ls;
    body_left_next         = e_bl;
    record_start_next      = e_rs;
    offset_in_block_next   = e_off;
    block_counter_next     = e_bc;
    fault_latched_next     = e_fault;
    rec_done   = 1'b0;
    fault_hit  = 1'b0;
    fault_kind = FAULT_NONE;
    rep_start  = e_rs;
    rep_enc    = '0;
    rep_body   = '0;
    span       = '0;

    if (!e_fault) begin
      if (cmd.has_byte) begin
        if (e_off >= MAX_OFF) begin
          // no prefix can start this late in a legal block
          fault_hit  = 1'b1;
          fault_kind = FAULT_TRUNC_LEN;
          rep_start  = e_rs;
        end else begin
          offset_in_block_next = e_off + 1'b1;
          if (e_phase == PHASE_LENGTH) begin
            case (e_pbs)
              2'd0: begin
                record_start_next = e_off[RW-1:0];
                length_shift_next = {24'b0, cmd.byte_value};
              end
              2'd1: length_shift_next[15:8]  = cmd.byte_value;
              2'd2: length_shift_next[23:16] = cmd.byte_value;
              2'd3: length_shift_next[31:24] = cmd.byte_value;
              default: length_shift_next = e_ls;
            endcase
            prefix_bytes_seen_next = e_pbs + 1'b1;
            if (e_pbs == 2'd3) begin
              span = {1'b0, length_shift_next} + 33'd4 + 33'(record_start_next);
              rep_start = record_start_next;
              if (length_shift_next[31] || length_shift_next < {16'b0, min_body_size}) begin
                fault_hit  = 1'b1;
                fault_kind = FAULT_SMALL_LEN;
              end else if (span > MAX_SPAN) begin
                fault_hit  = 1'b1;
                fault_kind = FAULT_TRUNC_BODY;
              end else if (length_shift_next == '0) begin
                rec_done = 1'b1;
                rep_enc  = 17'd4;
                rep_body = '0;
              end else begin
                body_left_next = length_shift_next[OW-1:0];
                phase_next     = PHASE_BODY;
              end
            end
          end else begin
            body_left_next = e_bl - 1'b1;
            if (body_left_next == '0) begin
              rec_done   = 1'b1;
              rep_start  = e_rs;
              rep_enc    = e_ls[16:0] + 17'd4;
              rep_body   = e_ls[15:0];
              phase_next = PHASE_LENGTH;
            end
          end
        end
      end

      if (!fault_hit && cmd.block_end) begin
        if (phase_next == PHASE_LENGTH && prefix_bytes_seen_next != '0) begin
          fault_hit  = 1'b1;
          fault_kind = FAULT_TRUNC_LEN;
          rep_start  = record_start_next;
        end else if (phase_next == PHASE_BODY) begin
          fault_hit  = 1'b1;
          fault_kind = FAULT_TRUNC_BODY;
          rep_start  = record_start_next;
        end else begin
          phase_next             = PHASE_LENGTH;
          prefix_bytes_seen_next = '0;
          length_shift_next      = '0;
          body_left_next         = '0;
          record_start_next      = '0;
          offset_in_block_next   = '0;
          block_counter_next     = (e_bc == LAST_BLOCK) ? '0 : e_bc + 1'b1;
        end
      end

      if (fault_hit) begin
        fault_latched_next = 1'b1;
      end
    end
  end

  // result item
  always_comb begin
    start_wide = {16'b0, rep_start};
    block_wide = {16'b0, e_bc};
    res_next.record_ready  = rec_done;
    res_next.record_offset = start_wide[15:0];
    res_next.total_size    = rec_done ? rep_enc : 17'd0;
    res_next.body_size     = rec_done ? rep_body : 16'd0;
    res_next.block_number  = block_wide[15:0];
    res_next.fault_code    = fault_hit ? fault_kind : FAULT_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PHASE_LENGTH;
      prefix_bytes_seen <= '0;
      length_shift      <= '0;
      body_left         <= '0;
      record_start      <= '0;
      offset_in_block   <= '0;
      block_counter     <= '0;
      fault_latched     <= 1'b0;
      res_valid         <= 1'b0;
    end else begin
      if (pop) begin
        phase             <= phase_next;
        prefix_bytes_seen <= prefix_bytes_seen_next;
        length_shift      <= length_shift_next;
        body_left         <= body_left_next;
        record_start      <= record_start_next;
        offset_in_block   <= offset_in_block_next;
        block_counter     <= block_counter_next;
        fault_latched     <= fault_latched_next;
      end
      if (pop && (rec_done || fault_hit)) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (rec_done || fault_hit)) begin
      res <= res_next;
    end
  end

endmodule

@@ hdl/bam_record_splitter_unit.sv @@
`timescale 1ns / 1ps
// An accepted item waits in the item queue; its result is registered on its pop.
// Throughput: 1 item per cycle, set by the back end deframer, unless a result waits.
// A 4-entry item queue lets the input keep flowing while a result waits to be taken.
// Reset (rst, synchronous): queue empty, no result pending, deframer reading a length
// at offset 0 of block 0 with no fault, min_body_size back to 32.
module bam_record_splitter_unit
  import bam_rs_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
  parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] min_body_size;
  q_status_t   q_status;
  logic        push;
  cmd_t        push_data;
  logic        pop;
  cmd_t        pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_body_size <= DEF_MIN_BODY_SIZE;
    end else if (cfg_valid) begin
      min_body_size <= cfg_data;
    end
  end

  bam_rs_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  bam_rs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  bam_rs_back #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
    .MAX_BLOCKS      (MAX_BLOCKS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .min_body_size (min_body_size),
    .cmd_valid     (q_status.nonempty),
    .cmd           (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

  a_record_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.record_ready |->
      out_data.fault_code == FAULT_NONE &&
      out_data.total_size[15:0] == out_data.body_size + 16'd4)
    else $error("record item carries a fault or inconsistent sizes");

  a_fault_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.record_ready |->
      out_data.fault_code != FAULT_NONE &&
      out_data.total_size == 17'd0 && out_data.body_size == 16'd0)
    else $error("fault item without a code or with nonzero sizes");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending right after reset");

endmodule
